>>> design/adlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adlt_pkg
// Shared types, codes and helpers for the Adalight / TPM2 frame parser.
// ----------------------------------------------------------------------------
package adlt_pkg;

    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 56;
    localparam int OUT_USER_W   = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [1:0] KIND_PIXEL   = 2'd0;
    localparam logic [1:0] KIND_PING    = 2'd1;
    localparam logic [1:0] KIND_COMMAND = 2'd2;

    localparam logic [7:0] BYTE_ADA_A   = 8'h41;
    localparam logic [7:0] BYTE_ADA_D   = 8'h64;
    localparam logic [7:0] BYTE_ADA_LA  = 8'h61;
    localparam logic [7:0] BYTE_TPM2    = 8'hC9;
    localparam logic [7:0] TPM_DATA     = 8'hDA;
    localparam logic [7:0] TPM_PING     = 8'hAA;
    localparam logic [7:0] PING_REPLY   = 8'hAC;
    localparam logic [7:0] ADA_CHECK_XOR = 8'h55;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        write_enable;
        logic        last_pixel;
        logic [7:0]  command_byte;
    } t_result;

    // (hi * 256) / 3 through a reciprocal; exact for every 8-bit hi.
    function automatic logic [15:0] div3_hi(input logic [7:0] hi);
        logic [23:0] prod;
        begin
            prod = 24'(hi) * 24'd43691;
            return 16'(prod >> 9);
        end
    endfunction

    // lo / 3 through a reciprocal; exact for every 8-bit lo.
    function automatic logic [7:0] div3_lo(input logic [7:0] lo);
        logic [15:0] prod;
        begin
            prod = 16'(lo) * 16'd171;
            return 8'(prod >> 9);
        end
    endfunction

endpackage
`default_nettype wire

>>> design/adlt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adlt_front
// Header hunting and frame parsing state machine; emits one result record
// per transfer that produces output.
// ----------------------------------------------------------------------------
module adlt_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_pixel_we,
    output logic                  o_push,
    output adlt_pkg::t_result     o_item
);
    import adlt_pkg::*;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_ADA_D     = 4'd1;
    localparam logic [3:0] ST_ADA_A     = 4'd2;
    localparam logic [3:0] ST_ADA_HI    = 4'd3;
    localparam logic [3:0] ST_ADA_LO    = 4'd4;
    localparam logic [3:0] ST_ADA_CHECK = 4'd5;
    localparam logic [3:0] ST_RED       = 4'd6;
    localparam logic [3:0] ST_GREEN     = 4'd7;
    localparam logic [3:0] ST_BLUE      = 4'd8;
    localparam logic [3:0] ST_TPM_TYPE  = 4'd9;
    localparam logic [3:0] ST_TPM_HI    = 4'd10;
    localparam logic [3:0] ST_TPM_LO    = 4'd11;

    logic [3:0]  r_state,       n_state;
    logic [15:0] r_pixels_left, n_pixels_left;
    logic [15:0] r_next_pixel,  n_next_pixel;
    logic [7:0]  r_check,       n_check;
    logic [7:0]  r_red,         n_red;
    logic [7:0]  r_green,       n_green;
    logic [15:0] pl_dec;

    assign pl_dec = r_pixels_left - 16'd1;

    always_comb begin
        n_state       = r_state;
        n_pixels_left = r_pixels_left;
        n_next_pixel  = r_next_pixel;
        n_check       = r_check;
        n_red         = r_red;
        n_green       = r_green;
        o_push        = 1'b0;
        o_item        = '0;
        if (i_accept) begin
            case (r_state)
                ST_ADA_D: begin
                    n_state = (i_byte == BYTE_ADA_D) ? ST_ADA_A : ST_IDLE;
                end
                ST_ADA_A: begin
                    n_state = (i_byte == BYTE_ADA_LA) ? ST_ADA_HI : ST_IDLE;
                end
                ST_ADA_HI: begin
                    n_next_pixel  = '0;
                    n_pixels_left = {i_byte, 8'd0};
                    n_check       = i_byte;
                    n_state       = ST_ADA_LO;
                end
                ST_ADA_LO: begin
                    n_pixels_left = r_pixels_left + 16'(i_byte) + 16'd1;
                    n_check       = r_check ^ i_byte ^ ADA_CHECK_XOR;
                    n_state       = ST_ADA_CHECK;
                end
                ST_ADA_CHECK: begin
                    n_state = (r_check == i_byte) ? ST_RED : ST_IDLE;
                end
                ST_TPM_TYPE: begin
                    n_state = ST_IDLE;
                    if (i_byte == TPM_DATA) begin
                        n_state = ST_TPM_HI;
                    end else if (i_byte == TPM_PING) begin
                        o_push              = 1'b1;
                        o_item.kind         = KIND_PING;
                        o_item.command_byte = PING_REPLY;
                    end
                end
                ST_TPM_HI: begin
                    n_next_pixel  = '0;
                    n_pixels_left = div3_hi(i_byte);
                    n_state       = ST_TPM_LO;
                end
                ST_TPM_LO: begin
                    n_pixels_left = r_pixels_left + 16'(div3_lo(i_byte));
                    n_state       = ST_RED;
                end
                ST_RED: begin
                    n_red   = i_byte;
                    n_state = ST_GREEN;
                end
                ST_GREEN: begin
                    n_green = i_byte;
                    n_state = ST_BLUE;
                end
                ST_BLUE: begin
                    o_push              = 1'b1;
                    o_item.kind         = KIND_PIXEL;
                    o_item.pixel_index  = r_next_pixel;
                    o_item.red          = r_red;
                    o_item.green        = r_green;
                    o_item.blue         = i_byte;
                    o_item.write_enable = i_pixel_we;
                    o_item.last_pixel   = (pl_dec == 16'd0);
                    if (i_pixel_we) begin
                        n_next_pixel = r_next_pixel + 16'd1;
                    end
                    n_pixels_left = pl_dec;
                    n_state       = (pl_dec == 16'd0) ? ST_IDLE : ST_RED;
                end
                default: begin
                    if (i_byte == BYTE_ADA_A) begin
                        n_state = ST_ADA_D;
                    end else if (i_byte == BYTE_TPM2) begin
                        n_state = ST_TPM_TYPE;
                    end else begin
                        n_state             = ST_IDLE;
                        o_push              = 1'b1;
                        o_item.kind         = KIND_COMMAND;
                        o_item.command_byte = i_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pixels_left <= '0;
            r_next_pixel  <= '0;
            r_check       <= '0;
            r_red         <= '0;
            r_green       <= '0;
        end else begin
            r_state       <= n_state;
            r_pixels_left <= n_pixels_left;
            r_next_pixel  <= n_next_pixel;
            r_check       <= n_check;
            r_red         <= n_red;
            r_green       <= n_green;
        end
    end

endmodule
`default_nettype wire

>>> design/adlt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adlt_queue
// Short first-in first-out queue of result records between the parser and
// the output stage.
// ----------------------------------------------------------------------------
module adlt_queue #(
    parameter int DEPTH = adlt_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  adlt_pkg::t_result     i_item,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output adlt_pkg::t_result     o_head
);
    import adlt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> design/adlt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adlt_back
// Output register stage; pulls records from the queue and presents them
// on the master-side stream until each transfer completes.
// ----------------------------------------------------------------------------
module adlt_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  adlt_pkg::t_result     i_head,
    output logic                  o_pop,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output adlt_pkg::t_result     o_out_item
);
    import adlt_pkg::*;

    logic    r_valid;
    t_result r_item;
    logic    load;

    assign load        = !i_empty && (!r_valid || i_out_ready);
    assign o_pop       = load;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_head;
        end
    end

endmodule
`default_nettype wire

>>> design/adalight_tpm2_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adalight_tpm2_frame_parser
// Parses Adalight and TPM2 serial frames into pixel writes, ping replies
// and pass-through command bytes.
// Result path: a byte that produces a result is parsed combinationally,
// written into the queue and then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full.
// Reset: synchronous, active low; parser returns to header hunting, queue
// and output stage empty, pixel write enable set to 1.
// ----------------------------------------------------------------------------
module adalight_tpm2_frame_parser #(
    parameter int QUEUE_DEPTH = adlt_pkg::QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [adlt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] pixel_index, [23:16] red, [31:24] green, [39:32] blue,
    // [40] write_enable, [48:41] command_byte, [55:49] zero
    output logic [adlt_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // [1:0] kind
    output logic [adlt_pkg::OUT_USER_W-1:0]        m_axis_tuser,
    output logic                                   m_axis_tlast
);
    import adlt_pkg::*;

    logic    r_pixel_we;
    logic    accept;
    logic    push;
    t_result push_item;
    logic    q_full;
    logic    q_empty;
    t_result q_head;
    logic    pop;
    t_result out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_we <= 1'b1;
        end else if (i_cfg_we) begin
            r_pixel_we <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    adlt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (s_axis_tdata),
        .i_pixel_we (r_pixel_we),
        .o_push     (push),
        .o_item     (push_item)
    );

    adlt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    adlt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_item  (out_item)
    );

    assign m_axis_tdata = {7'd0, out_item.command_byte, out_item.write_enable,
                           out_item.blue, out_item.green, out_item.red,
                           out_item.pixel_index};
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last_pixel;

endmodule
`default_nettype wire

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Adalight / TPM2 frame parser. Serial bytes go
// in as stream transfers, first from a short table of fixed cases and then
// as random frames, pings, broken headers and stray command bytes. The
// fixed cases carry their own expected results; a behavioral parser inside
// the bench predicts the rest, and each output transfer is compared field by
// field. The last phase runs with no idling on either side.
// ----------------------------------------------------------------------------
module tb;
    import adlt_pkg::*;

    localparam int          NUM_DIR     = 24;
    localparam int          PHASE_BYTES = 200;
    localparam int          LONG_HOLD   = 300;
    localparam int          SETTLE      = 6;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    typedef enum logic [3:0] {
        PS_IDLE, PS_ADA_D, PS_ADA_A, PS_ADA_HI, PS_ADA_LO, PS_ADA_CHECK,
        PS_RED, PS_GREEN, PS_BLUE, PS_TPM_TYPE, PS_TPM_HI, PS_TPM_LO
    } t_parse_state;

    typedef struct {
        logic [7:0]  rx;
        bit          typed;
        bit          has_res;
        logic [1:0]  kind;
        logic [15:0] idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        we;
        logic        last;
        logic [7:0]  cmd;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_wdata = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    t_parse_state frame_state = PS_IDLE;
    logic [15:0]  px_left = '0;
    logic [15:0]  px_next = '0;
    logic [7:0]   hdr_chk = '0;
    logic [7:0]   held_r = '0;
    logic [7:0]   held_g = '0;
    logic         pix_we = 1'b1;

    t_result      pending_results[$];
    t_stim_row    row_plan[$];
    int           mismatches = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  cycle_count = 0;
    bit           idling_on = 1'b0;
    int           hold_asked = 0;
    int           hold_seen = 0;
    int           stall_left = 0;

    t_stim_row stim_tbl [NUM_DIR] = '{
        '{8'h00, 1, 1, KIND_COMMAND, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 1, 1, KIND_COMMAND, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF},
        '{BYTE_TPM2, 1, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{TPM_PING, 1, 1, KIND_PING, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, PING_REPLY},
        '{BYTE_TPM2, 1, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{BYTE_ADA_A, 1, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{BYTE_ADA_A, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{BYTE_ADA_D, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{BYTE_ADA_A, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{BYTE_ADA_D, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{BYTE_ADA_LA, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h01, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{BYTE_TPM2, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{TPM_DATA, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h03, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'hFF, 0, 0, KIND_PIXEL, 16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1, 1, KIND_PIXEL, 16'd0, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b1, 8'h00}
    };

    adalight_tpm2_frame_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit parse_rx_byte(input logic [7:0] rx, output t_result res);
        bit got;
        got = 1'b0;
        res = '0;
        case (frame_state)
            PS_ADA_D: frame_state = (rx == BYTE_ADA_D) ? PS_ADA_A : PS_IDLE;
            PS_ADA_A: frame_state = (rx == BYTE_ADA_LA) ? PS_ADA_HI : PS_IDLE;
            PS_ADA_HI: begin
                px_next = '0;
                px_left = {rx, 8'h00};
                hdr_chk = rx;
                frame_state = PS_ADA_LO;
            end
            PS_ADA_LO: begin
                px_left = px_left + 16'(rx) + 16'd1;
                hdr_chk = hdr_chk ^ rx ^ ADA_CHECK_XOR;
                frame_state = PS_ADA_CHECK;
            end
            PS_ADA_CHECK: frame_state = (hdr_chk == rx) ? PS_RED : PS_IDLE;
            PS_TPM_TYPE: begin
                frame_state = PS_IDLE;
                if (rx == TPM_DATA) begin
                    frame_state = PS_TPM_HI;
                end else if (rx == TPM_PING) begin
                    got = 1'b1;
                    res.kind = KIND_PING;
                    res.command_byte = PING_REPLY;
                end
            end
            PS_TPM_HI: begin
                px_next = '0;
                px_left = {rx, 8'h00} / 16'd3;
                frame_state = PS_TPM_LO;
            end
            PS_TPM_LO: begin
                px_left = px_left + 16'(rx / 8'd3);
                frame_state = PS_RED;
            end
            PS_RED: begin
                held_r = rx;
                frame_state = PS_GREEN;
            end
            PS_GREEN: begin
                held_g = rx;
                frame_state = PS_BLUE;
            end
            PS_BLUE: begin
                got = 1'b1;
                res.kind = KIND_PIXEL;
                res.pixel_index = px_next;
                res.red = held_r;
                res.green = held_g;
                res.blue = rx;
                res.write_enable = pix_we;
                if (pix_we) begin
                    px_next = px_next + 16'd1;
                end
                px_left = px_left - 16'd1;
                if (px_left != 16'd0) begin
                    frame_state = PS_RED;
                end else begin
                    res.last_pixel = 1'b1;
                    frame_state = PS_IDLE;
                end
            end
            default: begin
                if (rx == BYTE_ADA_A) begin
                    frame_state = PS_ADA_D;
                end else if (rx == BYTE_TPM2) begin
                    frame_state = PS_TPM_TYPE;
                end else begin
                    frame_state = PS_IDLE;
                    got = 1'b1;
                    res.kind = KIND_COMMAND;
                    res.command_byte = rx;
                end
            end
        endcase
        return got;
    endfunction

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, seen);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result   want;
        bit        made;
        t_stim_row row;
        if (!i_rst_n) begin
            frame_state = PS_IDLE;
            px_left = '0;
            px_next = '0;
            hdr_chk = '0;
            held_r = '0;
            held_g = '0;
            pix_we = 1'b1;
        end else begin
            if (i_cfg_we) begin
                pix_we = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                made = parse_rx_byte(s_axis_tdata, want);
                if (row_plan.size() != 0) begin
                    row = row_plan.pop_front();
                    if (row.typed) begin
                        made = row.has_res;
                        want = '{kind: row.kind, pixel_index: row.idx, red: row.red,
                                 green: row.green, blue: row.blue, write_enable: row.we,
                                 last_pixel: row.last, command_byte: row.cmd};
                    end
                end
                if (made) begin
                    pending_results.push_back(want);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no expectation, actual kind %h data %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
                    check_field("pixel_index", want.pixel_index, m_axis_tdata[15:0]);
                    check_field("red", 16'(want.red), 16'(m_axis_tdata[23:16]));
                    check_field("green", 16'(want.green), 16'(m_axis_tdata[31:24]));
                    check_field("blue", 16'(want.blue), 16'(m_axis_tdata[39:32]));
                    check_field("write_enable", 16'(want.write_enable),
                                16'(m_axis_tdata[40]));
                    check_field("last_pixel", 16'(want.last_pixel), 16'(m_axis_tlast));
                    check_field("command_byte", 16'(want.command_byte),
                                16'(m_axis_tdata[48:41]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            stall_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] rx);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rx;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_pix_we(input logic value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_sequence();
        int         pick;
        int         npix;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] odd;
        pick = $urandom_range(0, 99);
        odd = 8'($urandom_range(0, 255));
        if (pick < 30) begin
            hi = 8'h00;
            lo = 8'($urandom_range(0, 5));
            npix = lo + 1;
            send_byte(BYTE_ADA_A);
            send_byte(BYTE_ADA_D);
            send_byte(BYTE_ADA_LA);
            send_byte(hi);
            send_byte(lo);
            send_byte(hi ^ lo ^ ADA_CHECK_XOR);
            repeat (npix * 3) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 55) begin
            hi = ($urandom_range(0, 9) == 0) ? 8'h01 : 8'h00;
            lo = 8'($urandom_range(3, 20));
            npix = (int'(hi) * 256) / 3 + int'(lo) / 3;
            send_byte(BYTE_TPM2);
            send_byte(TPM_DATA);
            send_byte(hi);
            send_byte(lo);
            repeat (npix * 3) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 65) begin
            send_byte(BYTE_TPM2);
            send_byte(TPM_PING);
        end else if (pick < 70) begin
            if (odd == TPM_DATA || odd == TPM_PING) begin
                odd = 8'h00;
            end
            send_byte(BYTE_TPM2);
            send_byte(odd);
        end else if (pick < 80) begin
            send_byte(BYTE_ADA_A);
            case ($urandom_range(0, 2))
                0: send_byte((odd == BYTE_ADA_D) ? 8'h00 : odd);
                1: begin
                    send_byte(BYTE_ADA_D);
                    send_byte((odd == BYTE_ADA_LA) ? 8'h00 : odd);
                end
                default: begin
                    lo = 8'($urandom_range(0, 5));
                    send_byte(BYTE_ADA_D);
                    send_byte(BYTE_ADA_LA);
                    send_byte(8'h00);
                    send_byte(lo);
                    send_byte(lo ^ ADA_CHECK_XOR ^ (8'h01 << $urandom_range(0, 7)));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int unsigned phase_start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idling_on <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++) begin
            row_plan.push_back(stim_tbl[i]);
            send_byte(stim_tbl[i].rx);
        end
        drain_all();

        for (int p = 0; p < 4; p++) begin
            write_pix_we(p % 2 == 0);
            idling_on <= (p != 3);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if (p == 1 && hold_asked == 0 && bytes_sent - phase_start >= 60) begin
                    hold_asked <= hold_asked + 1;
                end
                send_random_sequence();
            end
            drain_all();
        end

        while (frame_state != PS_IDLE) begin
            send_byte(8'($urandom_range(0, 255)));
            drain_all();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
design/adlt_pkg.sv
design/adlt_front.sv
design/adlt_queue.sv
design/adlt_back.sv
design/adalight_tpm2_frame_parser.sv
verif/tb.sv
